// ----- design/cau_pkg.sv -----
// Shared constants, codes and pipeline payload types of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int MAG_W      = PROD_W - FRAC_BITS + 1;
    localparam int QUO_BITS   = DATA_WIDTH + 1;
    localparam int REM_W      = PROD_W + FRAC_BITS;
    localparam int DEN_W      = PROD_W;
    localparam int DSH_W      = DEN_W + QUO_BITS - 1;
    localparam int DIV_STAGES = QUO_BITS;
    localparam int NUM_STAGES = DIV_STAGES + 3;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_CONJ = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAT      = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [REM_W-1:0] rem;
    } t_part;

    typedef struct packed {
        t_op              op;
        logic             zero;
        logic [DSH_W-1:0] den_sh;
        t_part            re;
        t_part            im;
    } t_work;
endpackage
`default_nettype wire

// ----- design/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, multiply, divide, conjugate on Q4.12 operands.
// Input channel: i_valid / o_stall carry one word (i_kind and four operand
// parts); a word is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result word (o_res_re,
// o_res_im, o_status); a word is taken with o_valid high and i_stall low.
// The datapath is a 20-stage pipeline: one multiplier stage, one stage that
// forms magnitudes and the divide dividend, 17 restoring divider stages (one
// quotient bit each) and an output saturation stage. Every operation takes
// the same path, so results leave in input order. Throughput is one word
// per cycle while i_stall is low. Each stage has a valid bit and loads
// when it is empty or its successor loads, so a stall of the receiver only
// backs up the stages that hold words; empty stages still fill, and o_stall
// rises only when all 20 stages hold words and i_stall is high.
// Synchronous reset (i_rst_n low) empties the pipeline; no other state.
`default_nettype none
module complex_arithmetic_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_kind,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_im,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]      o_res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]      o_res_im,
    output logic [1:0]                                 o_status
);
    import cau_pkg::*;

    logic [NUM_STAGES-1:0] r_valid, n_valid, ready;
    t_work                 work [DIV_STAGES+1];

    always_comb begin
        ready[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ready[k] = !r_valid[k] || ready[k+1];
        end
        n_valid[0] = ready[0] ? i_valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = ready[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    cau_front u_front (
        .i_clk  (i_clk),
        .i_en_a (ready[0]),
        .i_en_b (ready[1]),
        .i_kind (i_kind),
        .i_a_re (i_a_re),
        .i_a_im (i_a_im),
        .i_b_re (i_b_re),
        .i_b_im (i_b_im),
        .o_work (work[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        cau_div_step u_step (
            .i_clk  (i_clk),
            .i_en   (ready[g+2]),
            .i_work (work[g]),
            .o_work (work[g+1])
        );
    end

    cau_back u_back (
        .i_clk    (i_clk),
        .i_en     (ready[NUM_STAGES-1]),
        .i_work   (work[DIV_STAGES]),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

    assign o_stall = !ready[0];
    assign o_valid = r_valid[NUM_STAGES-1];

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid) && i_stall)
        else $error("input stalled while pipeline has room");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV_ZERO |-> o_res_re == '0 && o_res_im == '0)
        else $error("zero modulus result not cleared");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_SAT || o_status == ST_DIV_ZERO)
        else $error("undefined status code");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && !ready[1] |=> r_valid[0])
        else $error("word lost in first stage");
endmodule
`default_nettype wire

// ----- design/cau_front.sv -----
// Front end: operand products and sums, then sign/magnitude and dividend forming.
`default_nettype none
module cau_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en_a,
    input  wire logic                                  i_en_b,
    input  wire logic [1:0]                            i_kind,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_im,
    output cau_pkg::t_work                             o_work
);
    import cau_pkg::*;

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'((1 << FRAC_BITS) >> 1);

    function automatic logic [PROD_W:0] abs_w(input logic signed [PROD_W:0] v);
        logic [PROD_W:0] r;
        r = v[PROD_W] ? (PROD_W + 1)'(-v) : (PROD_W + 1)'(v);
        return r;
    endfunction

    // stage A: products and sums
    t_op                          r_op;
    logic signed [PROD_W-1:0]     r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_p_br, r_p_bi;
    logic signed [DATA_WIDTH:0]   r_s_re, r_s_im;
    logic signed [DATA_WIDTH-1:0] r_a_re, r_a_im;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_op   <= t_op'(i_kind);
            r_p_rr <= i_a_re * i_b_re;
            r_p_ii <= i_a_im * i_b_im;
            r_p_ir <= i_a_im * i_b_re;
            r_p_ri <= i_a_re * i_b_im;
            r_p_br <= i_b_re * i_b_re;
            r_p_bi <= i_b_im * i_b_im;
            r_s_re <= (DATA_WIDTH + 1)'(i_a_re) + (DATA_WIDTH + 1)'(i_b_re);
            r_s_im <= (DATA_WIDTH + 1)'(i_a_im) + (DATA_WIDTH + 1)'(i_b_im);
            r_a_re <= i_a_re;
            r_a_im <= i_a_im;
        end
    end

    // stage B: sign and magnitude of each part, or dividend for a divide
    logic signed [PROD_W:0] mul_re, mul_im, num_re, num_im, val_re, val_im;
    logic [DEN_W-1:0]       den;
    logic [PROD_W:0]        abs_re, abs_im;
    t_work                  n_work, r_work;

    always_comb begin
        mul_re = (PROD_W + 1)'(r_p_rr) - (PROD_W + 1)'(r_p_ii);
        mul_im = (PROD_W + 1)'(r_p_ir) + (PROD_W + 1)'(r_p_ri);
        num_re = (PROD_W + 1)'(r_p_rr) + (PROD_W + 1)'(r_p_ii);
        num_im = (PROD_W + 1)'(r_p_ir) - (PROD_W + 1)'(r_p_ri);
        den    = DEN_W'(unsigned'(r_p_br)) + DEN_W'(unsigned'(r_p_bi));
        case (r_op)
            OP_ADD: begin
                val_re = (PROD_W + 1)'(r_s_re);
                val_im = (PROD_W + 1)'(r_s_im);
            end
            OP_MUL: begin
                val_re = mul_re;
                val_im = mul_im;
            end
            OP_DIV: begin
                val_re = num_re;
                val_im = num_im;
            end
            default: begin
                val_re = (PROD_W + 1)'(r_a_re);
                val_im = -(PROD_W + 1)'(r_a_im);
            end
        endcase
        abs_re = abs_w(val_re);
        abs_im = abs_w(val_im);

        n_work.op     = r_op;
        n_work.zero   = (den == '0);
        n_work.den_sh = DSH_W'(den) << (QUO_BITS - 1);
        n_work.re.neg = val_re[PROD_W];
        n_work.im.neg = val_im[PROD_W];
        n_work.re.rem = REM_W'({abs_re, {FRAC_BITS{1'b0}}}) + REM_W'(den >> 1);
        n_work.im.rem = REM_W'({abs_im, {FRAC_BITS{1'b0}}}) + REM_W'(den >> 1);
        case (r_op)
            OP_MUL: begin
                n_work.re.mag = MAG_W'((abs_re + HALF) >> FRAC_BITS);
                n_work.im.mag = MAG_W'((abs_im + HALF) >> FRAC_BITS);
            end
            OP_DIV: begin
                n_work.re.mag = '0;
                n_work.im.mag = '0;
            end
            default: begin
                n_work.re.mag = MAG_W'(abs_re);
                n_work.im.mag = MAG_W'(abs_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;
endmodule
`default_nettype wire

// ----- design/cau_div_step.sv -----
// One restoring division step on both parts; other operations pass through.
`default_nettype none
module cau_div_step (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire cau_pkg::t_work i_work,
    output cau_pkg::t_work o_work
);
    import cau_pkg::*;

    function automatic t_part step(input t_part p, input logic [DSH_W-1:0] d);
        t_part r;
        logic  ge;
        ge    = DSH_W'(p.rem) >= d;
        r.neg = p.neg;
        r.rem = ge ? REM_W'(DSH_W'(p.rem) - d) : p.rem;
        r.mag = {p.mag[MAG_W-2:0], ge};
        return r;
    endfunction

    t_work n_work, r_work;

    always_comb begin
        n_work        = i_work;
        n_work.den_sh = i_work.den_sh >> 1;
        if (i_work.op == OP_DIV) begin
            n_work.re = step(i_work.re, i_work.den_sh);
            n_work.im = step(i_work.im, i_work.den_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;
endmodule
`default_nettype wire

// ----- design/cau_back.sv -----
// Output stage: saturate each part, form status, hold the result word.
`default_nettype none
module cau_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire cau_pkg::t_work                         i_work,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]       o_res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]       o_res_im,
    output logic [1:0]                                  o_status
);
    import cau_pkg::*;

    localparam logic [MAG_W-1:0] TOP = MAG_W'(1) << (DATA_WIDTH - 1);

    logic [MAG_W-1:0]             lim_re, lim_im, c_re, c_im;
    logic                         sat_re, sat_im;
    logic signed [DATA_WIDTH-1:0] n_res_re, n_res_im, r_res_re, r_res_im;
    logic [1:0]                   n_status, r_status;

    always_comb begin
        lim_re   = i_work.re.neg ? TOP : TOP - 1'b1;
        lim_im   = i_work.im.neg ? TOP : TOP - 1'b1;
        sat_re   = i_work.re.mag > lim_re;
        sat_im   = i_work.im.mag > lim_im;
        c_re     = sat_re ? lim_re : i_work.re.mag;
        c_im     = sat_im ? lim_im : i_work.im.mag;
        n_res_re = i_work.re.neg ? DATA_WIDTH'(-c_re) : DATA_WIDTH'(c_re);
        n_res_im = i_work.im.neg ? DATA_WIDTH'(-c_im) : DATA_WIDTH'(c_im);
        n_status = (sat_re || sat_im) ? ST_SAT : ST_OK;
        // zero modulus on divide: drop the quotient
        if (i_work.op == OP_DIV && i_work.zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = ST_DIV_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;
endmodule
`default_nettype wire
